[rtl/core/msrl_pkg.sv]
// ----------------------------------------------------------------------------
// msrl_pkg: shared types and constants of the memory slot range lookup
// Holds the command word passed from the front end to the back end through
// the queue, the stored slot record and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package msrl_pkg;

   localparam int ADDR_W     = 64;
   localparam int IDX_W      = 4;
   localparam int REQ_DATA_W = 328;  // 325 bits of fields, padded to whole bytes
   localparam int RSP_DATA_W = 72;   // 69 bits of fields, padded to whole bytes

   // Item kinds carried on req_tuser
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_WRITE  = 1'b1;

   // Classified command. For a lookup key_lo is the address and key_hi the
   // wrapped end of the access; for a write key_lo is the slot base and
   // key_hi the wrapped end of the slot.
   typedef struct packed {
      logic              is_write;
      logic              in_range;
      logic [IDX_W-1:0]  slot;
      logic [ADDR_W-1:0] key_lo;
      logic [ADDR_W-1:0] key_hi;
      logic [ADDR_W-1:0] host;
      logic              ent_valid;
   } cmd_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   // One stored slot
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] lim;
      logic [ADDR_W-1:0] host;
   } slot_type;

   // One result word
   typedef struct packed {
      logic [IDX_W-1:0]  match_index;
      logic              hit;
      logic [ADDR_W-1:0] host_base;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/memory_slot_range_lookup.sv]
// ----------------------------------------------------------------------------
// memory_slot_range_lookup: first-match guest to host address range table
// Top level joining the request front end, command queue and scan back end.
// ----------------------------------------------------------------------------
// Each request word is either a slot write (req_tuser = 1) or a lookup
// (req_tuser = 0) and gives exactly one response word, in order. A lookup
// scans the first min(NUM_SLOTS, 16) slots one slot per cycle, since the slot
// memory has one read port, stopping at the first valid slot whose base is at
// or below the address and whose end covers address plus size (both sums wrap
// at 2^64). A miss or a write answers with all-zero fields. Valid marks clear
// at reset, so no clearing pass is needed; the input is held off during reset
// and while the busy flag set by reset is still high, then takes words
// whenever the queue has room. A two-word queue lets requests be taken while
// a scan runs, and the output register lets the next command start while a
// response waits.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_slot_range_lookup
   import msrl_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // req_tdata, lowest bit up: slot_index[3:0], query_addr[67:4],
   // query_size[131:68], entry_base[195:132], entry_length[259:196],
   // entry_host[323:260], entry_valid[324], zero pad[327:325]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: func (0 lookup, 1 slot write)
   input  wire logic                  req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rsp_tdata, lowest bit up: host_base[63:0], hit[64],
   // match_index[68:65], zero pad[71:69]
   output      logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   cmd_type   q_cmd;
   qhead_type q_head;

   msrl_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   msrl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head)
   );

   msrl_back #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[rtl/core/msrl_front.sv]
// ----------------------------------------------------------------------------
// msrl_front: request intake and classification
// Unpacks a request word, sorts it into lookup or slot write, works out the
// wrapped end sum and the slot range check, and pushes it into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module msrl_front
   import msrl_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // req_tdata, lowest bit up: slot_index[3:0], query_addr[67:4],
   // query_size[131:68], entry_base[195:132], entry_length[259:196],
   // entry_host[323:260], entry_valid[324], zero pad[327:325]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: func (lookup or slot write)
   input  wire logic                  req_tuser,
   input  wire logic                  q_full,
   output      logic                  q_push,
   output      cmd_type               q_cmd
);

   localparam logic [8:0] SLOTS_LIM = 9'(NUM_SLOTS);

   logic [IDX_W-1:0]  slot_index;
   logic [ADDR_W-1:0] query_addr;
   logic [ADDR_W-1:0] query_size;
   logic [ADDR_W-1:0] entry_base;
   logic [ADDR_W-1:0] entry_length;
   logic [ADDR_W-1:0] entry_host;
   logic              entry_valid;
   logic              busy_ff;
   logic              busy_in;

   // Unpack the request word
   assign slot_index   = req_tdata[3:0];
   assign query_addr   = req_tdata[67:4];
   assign query_size   = req_tdata[131:68];
   assign entry_base   = req_tdata[195:132];
   assign entry_length = req_tdata[259:196];
   assign entry_host   = req_tdata[323:260];
   assign entry_valid  = req_tdata[324];

   // Hold off intake during and just after reset, while the busy flag is high, or while the queue is full
   assign busy_in    = 1'b0;
   assign req_tready = !q_full && !busy_ff;
   assign q_push     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Classify and precompute the end sums, both wrapping at 2^64
   always_comb begin
      q_cmd.is_write  = (req_tuser == FUNC_WRITE);
      q_cmd.in_range  = ({5'd0, slot_index} < SLOTS_LIM);
      q_cmd.slot      = slot_index;
      q_cmd.host      = entry_host;
      q_cmd.ent_valid = entry_valid;
      if (req_tuser == FUNC_WRITE) begin
         q_cmd.key_lo = entry_base;
         q_cmd.key_hi = entry_base + entry_length;
      end else begin
         q_cmd.key_lo = query_addr;
         q_cmd.key_hi = query_addr + query_size;
      end
   end

endmodule

`default_nettype wire

[rtl/core/msrl_queue.sv]
// ----------------------------------------------------------------------------
// msrl_queue: two-entry command queue
// Decouples request intake from slot execution so either side may stall.
// ----------------------------------------------------------------------------
`default_nettype none

module msrl_queue
   import msrl_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire cmd_type   push_cmd,
   output      logic      full,
   input  wire logic      pop,
   output      qhead_type head
);

   cmd_type    store_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full = (count_ff == 2'd2);
   assign head = '{valid: (count_ff != 2'd0), cmd: store_ff[rd_ptr_ff]};

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/core/msrl_back.sv]
// ----------------------------------------------------------------------------
// msrl_back: slot table and scan engine
// Writes slots into the slot memory, scans it one entry per cycle for the
// first covering valid slot, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msrl_back
   import msrl_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qhead_type             q_head,
   output      logic                  q_pop,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rsp_tdata, lowest bit up: host_base[63:0], hit[64],
   // match_index[68:65], zero pad[71:69]
   output      logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Only slots below 16 can be written through a 4-bit index
   localparam int SCAN_N = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
   localparam int AW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW     = $clog2(SCAN_N + 1);
   localparam logic [CW-1:0]    SCAN_END = CW'(SCAN_N);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_N - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] acc_end_ff, acc_end_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   rsp_type           res_ff, res_in;
   rsp_type           out_ff, out_in;
   logic              out_vld_ff, out_vld_in;

   slot_type          mem [NUM_SLOTS];
   slot_type          rd_data_ff;
   slot_type          wr_slot;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;
   logic              rd_en;
   logic              out_free;
   logic              match;

   assign wr_addr    = AW'(q_head.cmd.slot);
   assign rd_addr    = AW'(rd_idx_ff);
   assign wr_slot    = '{base: q_head.cmd.key_lo, lim: q_head.cmd.key_hi,
                         host: q_head.cmd.host};
   assign out_free   = !out_vld_ff || rsp_tready;
   assign match      = rd_vld_ff && (rd_data_ff.base <= addr_ff) &&
                       (acc_end_ff <= rd_data_ff.lim);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'd0, out_ff};

   // Sequence slot writes, scans and result hand-off
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      acc_end_in = acc_end_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      valid_in   = valid_ff;
      res_in     = res_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      q_pop      = 1'b0;
      mem_we     = 1'b0;
      rd_en      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (q_head.cmd.is_write) begin
                  if (q_head.cmd.in_range) begin
                     mem_we            = 1'b1;
                     valid_in[wr_addr] = q_head.cmd.ent_valid;
                  end
                  res_in   = '0;
                  state_in = ST_RESP;
               end else begin
                  addr_in    = q_head.cmd.key_lo;
                  acc_end_in = q_head.cmd.key_hi;
                  rd_idx_in  = '0;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue the next read
            if (rd_idx_ff != SCAN_END) begin
               rd_en      = 1'b1;
               rd_idx_in  = CW'(rd_idx_ff + 1'b1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = IDX_W'(rd_idx_ff);
            end else begin
               cmp_vld_in = 1'b0;
            end
            // check the entry read in the previous cycle
            if (cmp_vld_ff) begin
               if (match) begin
                  res_in     = '{match_index: cmp_idx_ff, hit: 1'b1,
                                 host_base: rd_data_ff.host};
                  cmp_vld_in = 1'b0;
                  state_in   = ST_RESP;
               end else if (cmp_idx_ff == LAST_IDX) begin
                  res_in     = '0;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rd_vld_in = rd_en ? valid_ff[rd_addr] : rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff   <= '0;
         out_vld_ff <= 1'b0;
         rd_idx_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff   <= valid_in;
         out_vld_ff <= out_vld_in;
         rd_idx_ff  <= rd_idx_in;
      end
      addr_ff    <= addr_in;
      acc_end_ff <= acc_end_in;
      cmp_idx_ff <= cmp_idx_in;
      rd_vld_ff  <= rd_vld_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_slot;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // A slot write in range leaves the valid mark as written
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.cmd.is_write && q_head.cmd.in_range) |=>
         (valid_ff[$past(wr_addr)] == $past(q_head.cmd.ent_valid)))
      else $error("slot valid mark not updated by write");

   // Pending compares exist only during a scan
   assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SCAN))
      else $error("compare pending outside scan");

   // A reported hit names a slot inside the scanned range
   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.hit) |-> (out_ff.match_index <= LAST_IDX))
      else $error("hit index beyond scanned slots");

endmodule

`default_nettype wire
